FILE: design/nftgt_pkg.sv
// Package with the opcodes, command codes and fill pattern of the NAND target interface.
package nftgt_pkg;

	localparam int OPCODE_W = 2;
	localparam int BYTE_W   = 8;
	localparam int ID_W     = 40;

	localparam logic [OPCODE_W-1:0] OP_CMD_WRITE  = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_ADDR_WRITE = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_READ       = 2'd2;

	localparam logic [BYTE_W-1:0] CMD_READ_ID   = 8'h90;
	localparam logic [BYTE_W-1:0] CMD_RESET     = 8'hFF;
	localparam logic [BYTE_W-1:0] CMD_PAGE_LOAD = 8'h30;

	localparam logic [ID_W-1:0] ID_RESET = 40'hC8_DA_90_95_44;

	localparam logic [BYTE_W-1:0] FILL_BASE  = 8'h64;
	localparam int                MARKER_LEN = 10;

	// Request from the event logic to the buffer sweep sequencer.
	typedef struct packed {
		logic id_load;
		logic page_load;
	} seq_start_t;

	// Status of the sequencer as seen by the event logic.
	typedef struct packed {
		logic busy;
		logic we;
	} seq_stat_t;

	// Ten-character marker that heads a loaded page.
	function automatic logic [BYTE_W-1:0] marker_byte(input logic [3:0] idx);
		logic [BYTE_W-1:0] b;
		case (idx)
			4'd0:    b = 8'h44;
			4'd1:    b = 8'h6F;
			4'd2:    b = 8'h6E;
			4'd3:    b = 8'h57;
			4'd4:    b = 8'h75;
			4'd5:    b = 8'h7A;
			4'd6:    b = 8'h68;
			4'd7:    b = 8'h65;
			4'd8:    b = 8'h72;
			4'd9:    b = 8'h65;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

FILE: design/nftgt_if.sv
// Valid/ready channel interfaces for bus events and for event results.
interface nftgt_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] bus_byte;

	modport source (output valid, output opcode, output bus_byte, input ready);
	modport sink (input valid, input opcode, input bus_byte, output ready);
endinterface

interface nftgt_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_byte;
	logic       read_valid;
	logic       busy_pulse;

	modport source (output valid, output read_byte, output read_valid, output busy_pulse,
		input ready);
	modport sink (input valid, input read_byte, input read_valid, input busy_pulse,
		output ready);
endinterface

FILE: design/nftgt_seq.sv
// Sweep sequencer that writes the ID bytes or the test pattern into the page buffer.
module nftgt_seq #(
	parameter int PAGE_BYTES = 2112
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  nftgt_pkg::seq_start_t            start,
	input  logic [nftgt_pkg::ID_W-1:0]       id_bytes,
	output nftgt_pkg::seq_stat_t             stat,
	output logic [$clog2(PAGE_BYTES)-1:0]    wr_addr,
	output logic [nftgt_pkg::BYTE_W-1:0]     wr_data
);
	import nftgt_pkg::*;

	localparam int AW = $clog2(PAGE_BYTES);

	logic          busy_q;
	logic          id_mode_q;
	logic [AW-1:0] cnt_q;
	logic [ID_W-1:0] id_sh_q;
	logic          last;
	logic [BYTE_W-1:0] fill_byte;

	assign last = id_mode_q ? (cnt_q == AW'(4)) : (cnt_q == AW'(PAGE_BYTES - 1));

	always_comb begin
		if (cnt_q < AW'(MARKER_LEN)) begin
			fill_byte = marker_byte(cnt_q[3:0]);
		end else begin
			fill_byte = {2'b00, cnt_q[5:0]} + FILL_BASE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			id_mode_q <= 1'b0;
			cnt_q     <= '0;
		end else if (start.id_load || start.page_load) begin
			busy_q    <= 1'b1;
			id_mode_q <= start.id_load;
			cnt_q     <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + AW'(1);
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	// The ID value is captured at the start so the sweep sees one consistent word.
	always_ff @(posedge clk) begin
		if (start.id_load) begin
			id_sh_q <= id_bytes;
		end else if (busy_q) begin
			id_sh_q <= {id_sh_q[ID_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
		end
	end

	assign stat.busy = busy_q;
	assign stat.we   = busy_q;
	assign wr_addr   = cnt_q;
	assign wr_data   = id_mode_q ? id_sh_q[ID_W-1:ID_W-BYTE_W] : fill_byte;

endmodule

FILE: design/nand_flash_target_interface_top.sv
// Top level of the NAND flash target interface: event decode, page buffer RAM and result path.
// Command writes, address writes and read strobes are taken one beat per cycle while no sweep
// runs and the result path is not stalled; a read strobe's byte is registered out of the page
// buffer RAM and the result beat leaves through an output register. An ID
// load holds off the input while its five bytes, and a page load while all PAGE_BYTES bytes,
// are swept through the single write port of the page buffer RAM. The page buffer is not
// cleared after reset.
module nand_flash_target_interface_top #(
	parameter int PAGE_BYTES = 2112
) (
	input  logic                       clk,
	input  logic                       arst_n,
	nftgt_in_if.sink                   in_ch,
	nftgt_out_if.source                out_ch,
	input  logic                       cfg_we,
	input  logic [nftgt_pkg::ID_W-1:0] cfg_wdata
);
	import nftgt_pkg::*;

	localparam int AW = $clog2(PAGE_BYTES);

	logic [ID_W-1:0]   id_q;
	logic [BYTE_W-1:0] cmd_q;
	logic [AW-1:0]     ptr_q;
	logic [AW-1:0]     ptr_nxt;

	logic [BYTE_W-1:0] mem [PAGE_BYTES];
	logic [BYTE_W-1:0] rd_data_q;
	logic              mem_we;
	logic [AW-1:0]     mem_addr;
	logic [BYTE_W-1:0] mem_wd;

	seq_start_t        seq_start;
	seq_stat_t         seq_stat;
	logic [AW-1:0]     seq_addr;
	logic [BYTE_W-1:0] seq_data;

	logic valid_s1;
	logic read_s1;
	logic busy_s1;
	logic adv;
	logic acc;
	logic is_cmd;
	logic is_addr;
	logic is_read;

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_rv_q;
	logic              out_busy_q;

	assign ptr_nxt = (ptr_q == AW'(PAGE_BYTES - 1)) ? '0 : ptr_q + AW'(1);

	assign adv         = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !seq_stat.busy && (!valid_s1 || adv);
	assign acc         = in_ch.valid && in_ch.ready;
	assign is_cmd      = acc && (in_ch.opcode == OP_CMD_WRITE);
	assign is_addr     = acc && (in_ch.opcode == OP_ADDR_WRITE);
	assign is_read     = acc && (in_ch.opcode == OP_READ);

	// The byte just written went to entry zero, so the zero-address check looks at it directly.
	assign seq_start.id_load   = is_addr && (cmd_q == CMD_READ_ID) && (ptr_nxt == AW'(1)) &&
		(in_ch.bus_byte == '0);
	assign seq_start.page_load = is_addr && (cmd_q == CMD_PAGE_LOAD) && (ptr_nxt == AW'(5));

	nftgt_seq #(
		.PAGE_BYTES(PAGE_BYTES)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (seq_start),
		.id_bytes (id_q),
		.stat     (seq_stat),
		.wr_addr  (seq_addr),
		.wr_data  (seq_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q <= ID_RESET;
		end else if (cfg_we) begin
			id_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= '0;
			ptr_q <= '0;
		end else if (is_cmd) begin
			cmd_q <= (in_ch.bus_byte == CMD_RESET) ? '0 : in_ch.bus_byte;
			ptr_q <= '0;
		end else if (is_addr) begin
			ptr_q <= (seq_start.id_load || seq_start.page_load) ? '0 : ptr_nxt;
		end else if (is_read) begin
			ptr_q <= ptr_nxt;
		end
	end

	// Address writes and sweep writes never meet: the input is held while the sweep runs.
	assign mem_we   = is_addr || seq_stat.we;
	assign mem_addr = is_addr ? ptr_q : seq_addr;
	assign mem_wd   = is_addr ? in_ch.bus_byte : seq_data;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wd;
		end
		if (is_read) begin
			rd_data_q <= mem[ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			read_s1 <= is_read;
			busy_s1 <= seq_start.page_load;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q <= read_s1 ? rd_data_q : '0;
			out_rv_q   <= read_s1;
			out_busy_q <= busy_s1;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.read_byte  = out_byte_q;
	assign out_ch.read_valid = out_rv_q;
	assign out_ch.busy_pulse = out_busy_q;

endmodule

FILE: tb/sv/nand_flash_target_interface_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the NAND flash target interface: bus events in, result beats checked.
module nand_flash_target_interface_top_tb;
	import nftgt_pkg::*;

	localparam int PAGE_BYTES = 2112;
	localparam logic [OPCODE_W-1:0] OP_NONE = 2'd3;
	localparam logic [8*MARKER_LEN-1:0] PAGE_MARKER = 80'h44_6F_6E_57_75_7A_68_65_72_65;
	localparam int PLAN_COPY = 0;
	localparam int CHECK_COPY = 1;
	localparam int STALL_LIMIT = 8 * PAGE_BYTES + 2000;
	localparam int PRINT_LIMIT = 30;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [BYTE_W-1:0]   bus_byte;
	} bus_event_t;

	typedef struct packed {
		logic [BYTE_W-1:0] read_byte;
		logic              read_valid;
		logic              busy_pulse;
	} result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [ID_W-1:0] cfg_wdata;

	nftgt_in_if in_ch();
	nftgt_out_if out_ch();

	nand_flash_target_interface_top #(.PAGE_BYTES(PAGE_BYTES)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Two copies of the target state: one advanced while planning stimulus, one on accepted beats.
	logic [BYTE_W-1:0] page_mem [2][PAGE_BYTES];
	bit                page_written [2][PAGE_BYTES];
	logic [BYTE_W-1:0] cur_cmd [2];
	int                slot [2];
	logic [ID_W-1:0]   id_reg [2];

	bus_event_t pending_events[$];
	result_t    expected_results[$];
	int         planned_items = 0;
	int         error_count = 0;
	int         result_beats = 0;
	int         idle_cycles = 0;
	int         send_gap = 0;
	int         send_steady = 0;
	int         recv_gap = 0;
	int         recv_steady = 0;
	bit         drain_hold = 1'b0;
	bus_event_t next_event;
	result_t    want;

	function automatic int next_slot(input int p);
		return (p >= PAGE_BYTES - 1) ? 0 : p + 1;
	endfunction

	function automatic void store_byte(input int c, input int idx, input logic [BYTE_W-1:0] v);
		page_mem[c][idx] = v;
		page_written[c][idx] = 1'b1;
	endfunction

	function automatic result_t target_event(input int c, input logic [OPCODE_W-1:0] op,
		input logic [BYTE_W-1:0] b);
		result_t r;
		int i;
		r = '0;
		case (op)
			OP_READ: begin
				r.read_byte = page_mem[c][slot[c]];
				r.read_valid = 1'b1;
				slot[c] = next_slot(slot[c]);
			end
			OP_CMD_WRITE, OP_ADDR_WRITE: begin
				if (op == OP_CMD_WRITE) begin
					cur_cmd[c] = b;
					slot[c] = 0;
				end else begin
					store_byte(c, slot[c], b);
					slot[c] = next_slot(slot[c]);
				end
				if (cur_cmd[c] == CMD_READ_ID && slot[c] == 1 && page_mem[c][0] == 8'h00) begin
					for (i = 0; i < 5; i++)
						store_byte(c, i, id_reg[c][ID_W-1-8*i -: 8]);
					slot[c] = 0;
				end
				if (cur_cmd[c] == CMD_RESET) begin
					slot[c] = 0;
					cur_cmd[c] = '0;
				end
				if (cur_cmd[c] == CMD_PAGE_LOAD && slot[c] == 5) begin
					for (i = 0; i < PAGE_BYTES; i++)
						store_byte(c, i, (i < MARKER_LEN) ? PAGE_MARKER[8*MARKER_LEN-1-8*i -: 8]
							: FILL_BASE + 8'(i % 64));
					slot[c] = 0;
					r.busy_pulse = 1'b1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [BYTE_W-1:0] random_byte();
		return 8'($urandom);
	endfunction

	function automatic logic [BYTE_W-1:0] random_cmd();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return CMD_READ_ID;
		if (r < 20) return CMD_PAGE_LOAD;
		if (r < 25) return CMD_RESET;
		return random_byte();
	endfunction

	// Mostly back-to-back beats, now and then a long run with none at all.
	function automatic int draw_gap(inout int steady);
		int r;
		if (steady > 0) begin
			steady--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			steady = $urandom_range(20, 80);
			return 0;
		end
		if (r < 50) return 0;
		if (r < 80) return $urandom_range(1, 2);
		if (r < 95) return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	function automatic void queue_event(input logic [OPCODE_W-1:0] op, input logic [BYTE_W-1:0] b);
		void'(target_event(PLAN_COPY, op, b));
		pending_events.push_back('{opcode: op, bus_byte: b});
		if (op != OP_NONE)
			planned_items++;
	endfunction

	// A read of a buffer byte that was never written is left out.
	function automatic void queue_read();
		if (page_written[PLAN_COPY][slot[PLAN_COPY]])
			queue_event(OP_READ, random_byte());
	endfunction

	function automatic void queue_page_load();
		queue_event(OP_CMD_WRITE, CMD_PAGE_LOAD);
		repeat (5) queue_event(OP_ADDR_WRITE, random_byte());
	endfunction

	function automatic void queue_directed();
		queue_event(OP_CMD_WRITE, CMD_READ_ID);
		queue_event(OP_ADDR_WRITE, 8'h00);
		repeat (5) queue_read();
		// A nonzero address byte must not load the ID.
		queue_event(OP_CMD_WRITE, CMD_READ_ID);
		queue_event(OP_ADDR_WRITE, 8'h01);
		queue_read();
		queue_event(OP_CMD_WRITE, CMD_PAGE_LOAD);
		queue_event(OP_ADDR_WRITE, 8'h00);
		queue_event(OP_ADDR_WRITE, 8'hFF);
		queue_event(OP_ADDR_WRITE, 8'h5A);
		queue_event(OP_ADDR_WRITE, 8'hA5);
		queue_event(OP_ADDR_WRITE, 8'h3C);
		repeat (3) queue_read();
		queue_event(OP_CMD_WRITE, CMD_RESET);
		queue_read();
		queue_event(OP_NONE, 8'hFF);
		queue_event(OP_NONE, 8'h00);
		queue_event(OP_READ, 8'hFF);
	endfunction

	// Walk the pointer through the whole page and across its end.
	function automatic void queue_wrap_sweep(input bit cross_by_write);
		queue_page_load();
		repeat (10) queue_read();
		while (slot[PLAN_COPY] < PAGE_BYTES - 3) begin
			if ($urandom_range(0, 4) == 0)
				queue_event(OP_ADDR_WRITE, random_byte());
			else
				queue_read();
		end
		repeat (6) begin
			if (cross_by_write)
				queue_event(OP_ADDR_WRITE, random_byte());
			else
				queue_read();
		end
	endfunction

	function automatic void queue_random(input int budget);
		int stop_at;
		int r;
		logic [OPCODE_W-1:0] op;
		stop_at = planned_items + budget;
		while (planned_items < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 15) begin
				queue_event(OP_CMD_WRITE, CMD_READ_ID);
				queue_event(OP_ADDR_WRITE, ($urandom_range(0, 3) == 0) ? random_byte() : 8'h00);
				repeat ($urandom_range(0, 7)) queue_read();
			end else if (r < 33) begin
				queue_page_load();
				repeat ($urandom_range(0, 20)) queue_read();
			end else if (r < 43) begin
				// Page load cut short, sometimes with reads moving the pointer in between.
				queue_event(OP_CMD_WRITE, CMD_PAGE_LOAD);
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 3) == 0)
						queue_read();
					else
						queue_event(OP_ADDR_WRITE, random_byte());
				end
				queue_event(OP_CMD_WRITE, random_cmd());
				repeat ($urandom_range(0, 3)) queue_read();
			end else if (r < 63) begin
				queue_event(OP_CMD_WRITE, random_cmd());
				repeat ($urandom_range(1, 8)) queue_event(OP_ADDR_WRITE, random_byte());
				repeat ($urandom_range(0, 8)) queue_read();
			end else if (r < 68) begin
				queue_event(OP_CMD_WRITE, CMD_RESET);
				repeat ($urandom_range(0, 4)) queue_read();
			end else if (r < 83) begin
				repeat ($urandom_range(1, 6)) begin
					op = 2'($urandom_range(0, 3));
					if (op == OP_READ)
						queue_read();
					else
						queue_event(op, random_byte());
				end
			end else begin
				repeat ($urandom_range(1, 30)) queue_read();
			end
		end
	endfunction

	function automatic logic [ID_W-1:0] id_for_phase(input int ph);
		case (ph)
			0: return '0;
			1: return '1;
			default: return {8'($urandom), 32'($urandom)};
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int got, input int expected_val);
		if (error_count < PRINT_LIMIT)
			$display("result beat %0d: %s is %0h, expected %0h", result_beats, what, got,
				expected_val);
		error_count++;
	endtask

	task automatic write_id(input logic [ID_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		id_reg[PLAN_COPY] = v;
		id_reg[CHECK_COPY] = v;
	endtask

	task automatic wait_drained(input int tail);
		do
			@(negedge clk);
		while (pending_events.size() != 0 || expected_results.size() != 0 || in_ch.valid);
		repeat (tail) @(posedge clk);
	endtask

	// Event driver: presents queued bus events and predicts the result of each accepted beat.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.opcode <= OP_CMD_WRITE;
			in_ch.bus_byte <= '0;
			send_gap = 0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				expected_results.push_back(target_event(CHECK_COPY, in_ch.opcode, in_ch.bus_byte));
			if (!in_ch.valid || in_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_ch.valid <= 1'b0;
				end else if (drain_hold && expected_results.size() != 0) begin
					in_ch.valid <= 1'b0;
				end else if (pending_events.size() != 0) begin
					next_event = pending_events.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.opcode <= next_event.opcode;
					in_ch.bus_byte <= next_event.bus_byte;
					send_gap = draw_gap(send_steady);
					drain_hold = ($urandom_range(0, 59) == 0);
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: stalls the output at random and checks every beat against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected beat, read_byte", out_ch.read_byte, 0);
				end else begin
					want = expected_results.pop_front();
					if (out_ch.read_byte !== want.read_byte)
						report_mismatch("read_byte", out_ch.read_byte, want.read_byte);
					if (out_ch.read_valid !== want.read_valid)
						report_mismatch("read_valid", out_ch.read_valid, want.read_valid);
					if (out_ch.busy_pulse !== want.busy_pulse)
						report_mismatch("busy_pulse", out_ch.busy_pulse, want.busy_pulse);
				end
				result_beats++;
			end
			if (recv_gap > 0) begin
				recv_gap--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				recv_gap = draw_gap(recv_steady);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("[nand_flash_target_interface_top] ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.opcode = OP_CMD_WRITE;
		in_ch.bus_byte = '0;
		out_ch.ready = 1'b0;
		for (int c = 0; c < 2; c++) begin
			cur_cmd[c] = '0;
			slot[c] = 0;
			id_reg[c] = ID_RESET;
			for (int i = 0; i < PAGE_BYTES; i++) begin
				page_mem[c][i] = '0;
				page_written[c][i] = 1'b0;
			end
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		queue_directed();
		wait_drained(PAGE_BYTES + 40);
		for (int ph = 0; ph < 5; ph++) begin
			write_id(id_for_phase(ph));
			@(negedge clk);
			if (ph == 1)
				queue_wrap_sweep(1'b0);
			if (ph == 3)
				queue_wrap_sweep(1'b1);
			queue_random(290);
			wait_drained((ph == 4) ? 50 : PAGE_BYTES + 40);
		end
		if (error_count == 0)
			$display("[nand_flash_target_interface_top] OK");
		else
			$display("[nand_flash_target_interface_top] ERROR");
		$finish;
	end

endmodule

FILE: nand_flash_target_interface_top.f
design/nftgt_pkg.sv
design/nftgt_if.sv
design/nftgt_seq.sv
design/nand_flash_target_interface_top.sv
tb/sv/nand_flash_target_interface_top_tb.sv
